// ----- sv/prct_pkg.sv -----
// shared types and constants of the palette recent color tracker
package prct_pkg;

  localparam int unsigned IdxW   = 8;
  localparam int unsigned ColorW = 32;
  localparam int unsigned CountW = 5;

  // item codes
  typedef enum logic [2:0] {
    ACT_LOAD   = 3'd0,
    ACT_CLEAR  = 3'd1,
    ACT_SELECT = 3'd2,
    ACT_RECORD = 3'd3,
    ACT_READ   = 3'd4
  } action_e;

  // one entry of the recent list as it moves along the cell row
  typedef struct packed {
    logic              vld;
    logic [IdxW-1:0]   idx;
    logic [ColorW-1:0] color;
  } rent_t;

  // command broadcast to every cell
  typedef struct packed {
    logic            push;
    logic            flush;
    logic [IdxW-1:0] key;
  } rcmd_t;

endpackage

// ----- sv/prct_pmem.sv -----
// palette memory: one write port, one registered read port, write-first
module prct_pmem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // same-cycle write to the read address returns the new data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/prct_cell.sv -----
// one cell of the move-to-front recent list
module prct_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  prct_pkg::rcmd_t cmd_i,
  input  prct_pkg::rent_t prev_i,
  input  logic            hit_i,
  output prct_pkg::rent_t ent_o,
  output logic            hit_o
);
  import prct_pkg::*;

  logic              vld_q;
  logic [IdxW-1:0]   idx_q;
  logic [ColorW-1:0] color_q;

  // a match upstream means the removed entry sits ahead of us: stay put
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (cmd_i.flush) begin
      vld_q <= 1'b0;
    end else if (cmd_i.push && !hit_i) begin
      vld_q <= prev_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && !hit_i) begin
      idx_q   <= prev_i.idx;
      color_q <= prev_i.color;
    end
  end

  assign ent_o = '{vld: vld_q, idx: idx_q, color: color_q};
  assign hit_o = hit_i || (vld_q && (idx_q == cmd_i.key));

endmodule

// ----- sv/palette_recent_color_tracker.sv -----
// top level of the palette recent color tracker
//
// palette recent color tracker: holds a color palette, an active index and a
// move-to-front list of recently used (index, color) pairs. every item gives
// exactly one result. on accepting an item the block applies all
// state changes (palette write, index, recent list push) and starts a read of
// the palette at the new active index; in the exec state it then loads the
// result register from the registered read data once that register is free
// or taken by out_ready_i. the block takes no new item until the result is
// loaded, but a new item is accepted while the previous result still sits in
// the result register. the recent list is a row of RECENT_LIMIT cells; on a
// record item the active pair enters cell zero and each cell takes its left
// neighbor's entry unless a cell to its left holds the same index, so a
// duplicate drops out and the tail beyond the limit falls off. palette
// entries have no reset and must be loaded before they are read; there is
// no clearing pass after reset.
module palette_recent_color_tracker #(
  parameter int unsigned PALETTE_ENTRIES  = 256,
  parameter int unsigned FIRST_SELECTABLE = 1,
  parameter int unsigned RECENT_LIMIT     = 16,
  parameter int unsigned COLOR_BITS       = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  action_i,
  input  logic [7:0]  index_i,
  input  logic [31:0] color_i,
  input  logic        load_first_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        ok_o,
  output logic        palette_present_o,
  output logic [7:0]  active_index_o,
  output logic        active_valid_o,
  output logic [31:0] active_color_o,
  output logic [4:0]  recent_count_o,
  output logic        slot_valid_o,
  output logic [7:0]  slot_index_o,
  output logic [31:0] slot_color_o
);
  import prct_pkg::*;

  // the index field is 8 bits, so no more than 256 entries are reachable
  localparam int unsigned PeLim = (PALETTE_ENTRIES > 256) ? 256 : PALETTE_ENTRIES;
  localparam int unsigned AW    = $clog2(PeLim);
  localparam int unsigned CW    = (COLOR_BITS < ColorW) ? COLOR_BITS : ColorW;
  localparam int unsigned LW    = $clog2(RECENT_LIMIT + 1);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e            state_q;
  logic              out_valid_q;
  logic              loaded_q, loaded_d;
  logic [IdxW-1:0]   cur_q, cur_d;
  logic [LW-1:0]     len_q, len_d;
  action_e           act_q;
  action_e           act;
  logic [IdxW-1:0]   idx_q;
  logic              ok_q, ok_acc;

  logic              ok_r, present_r, act_valid_r, slot_valid_r;
  logic [IdxW-1:0]   act_index_r, slot_index_r;
  logic [ColorW-1:0] act_color_r, slot_color_r;
  logic [CountW-1:0] count_r;

  logic              in_fire;
  logic              we;
  logic [CW-1:0]     rdata;
  logic              push, flush;
  rcmd_t             cmd;
  rent_t             head;
  rent_t             ent [RECENT_LIMIT];
  logic [RECENT_LIMIT:0]   hit;
  logic [RECENT_LIMIT-1:0] cell_vld;
  rent_t             slot_ent;
  logic              slot_hit;
  logic              act_valid;

  function automatic logic selectable(input logic [IdxW-1:0] x);
    return ({1'b0, x} >= 9'(FIRST_SELECTABLE)) && ({1'b0, x} < 9'(PeLim));
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign act        = action_e'(action_i);
  assign act_valid  = loaded_q && selectable(cur_q);

  // accept edge: all state changes of the item
  always_comb begin
    loaded_d = loaded_q;
    cur_d    = cur_q;
    len_d    = len_q;
    push     = 1'b0;
    flush    = 1'b0;
    we       = 1'b0;
    ok_acc   = 1'b0;
    if (in_fire) begin
      case (act)
        ACT_LOAD: begin
          ok_acc = 1'b1;
          we     = ({1'b0, index_i} < 9'(PeLim));
          if (load_first_i) begin
            loaded_d = 1'b1;
            cur_d    = IdxW'(FIRST_SELECTABLE);
            len_d    = '0;
            flush    = 1'b1;
          end
        end
        ACT_CLEAR: begin
          ok_acc   = 1'b1;
          loaded_d = 1'b0;
          cur_d    = IdxW'(FIRST_SELECTABLE);
          len_d    = '0;
          flush    = 1'b1;
        end
        ACT_SELECT: begin
          if (loaded_q && selectable(index_i)) begin
            cur_d  = index_i;
            ok_acc = 1'b1;
          end
        end
        ACT_RECORD: begin
          if (act_valid) begin
            push   = 1'b1;
            ok_acc = 1'b1;
            // a duplicate leaves the length alone, else grow up to the limit
            if (!hit[RECENT_LIMIT] && (len_q != LW'(RECENT_LIMIT))) begin
              len_d = len_q + LW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // palette memory; from the first accepted item on, its read data holds the color at the active index
  prct_pmem #(
    .DEPTH (PeLim),
    .AW    (AW),
    .DW    (CW)
  ) u_pmem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (index_i[AW-1:0]),
    .wdata_i (color_i[CW-1:0]),
    .re_i    (in_fire),
    .raddr_i (cur_d[AW-1:0]),
    .rdata_o (rdata)
  );

  // recent list: row of cells, the active pair enters at cell zero
  assign cmd    = '{push: push, flush: flush, key: cur_q};
  assign head   = '{vld: 1'b1, idx: cur_q, color: ColorW'(rdata)};
  assign hit[0] = 1'b0;

  for (genvar i = 0; i < RECENT_LIMIT; i++) begin : g_cell
    if (i == 0) begin : g_first
      prct_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .cmd_i  (cmd),
        .prev_i (head),
        .hit_i  (hit[i]),
        .ent_o  (ent[i]),
        .hit_o  (hit[i+1])
      );
    end else begin : g_rest
      prct_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .cmd_i  (cmd),
        .prev_i (ent[i-1]),
        .hit_i  (hit[i]),
        .ent_o  (ent[i]),
        .hit_o  (hit[i+1])
      );
    end
    assign cell_vld[i] = ent[i].vld;
  end

  // slot read for a read item; the list does not change on a read
  always_comb begin
    slot_ent = '0;
    for (int i = 0; i < RECENT_LIMIT; i++) begin
      if (idx_q == IdxW'(i)) begin
        slot_ent = ent[i];
      end
    end
  end

  assign slot_hit = (act_q == ACT_READ) && (idx_q < IdxW'(len_q));

  // result fields, built after the state update has settled
  always_comb begin
    ok_r         = (act_q == ACT_READ) ? slot_hit : ok_q;
    present_r    = loaded_q;
    act_index_r  = cur_q;
    act_valid_r  = act_valid;
    act_color_r  = act_valid ? ColorW'(rdata) : '0;
    count_r      = CountW'(len_q);
    slot_valid_r = slot_hit;
    slot_index_r = slot_hit ? slot_ent.idx : '0;
    slot_color_r = slot_hit ? slot_ent.color : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= ST_IDLE;
      out_valid_q       <= 1'b0;
      loaded_q          <= 1'b0;
      cur_q             <= IdxW'(FIRST_SELECTABLE);
      len_q             <= '0;
      act_q             <= ACT_LOAD;
      idx_q             <= '0;
      ok_q              <= 1'b0;
      ok_o              <= 1'b0;
      palette_present_o <= 1'b0;
      active_index_o    <= '0;
      active_valid_o    <= 1'b0;
      active_color_o    <= '0;
      recent_count_o    <= '0;
      slot_valid_o      <= 1'b0;
      slot_index_o      <= '0;
      slot_color_o      <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (out_valid_q && out_ready_i) begin
            out_valid_q <= 1'b0;
          end
          if (in_fire) begin
            loaded_q <= loaded_d;
            cur_q    <= cur_d;
            len_q    <= len_d;
            act_q    <= act;
            idx_q    <= index_i;
            ok_q     <= ok_acc;
            state_q  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          // result register free or emptied this cycle
          if (!out_valid_q || out_ready_i) begin
            out_valid_q       <= 1'b1;
            ok_o              <= ok_r;
            palette_present_o <= present_r;
            active_index_o    <= act_index_r;
            active_valid_o    <= act_valid_r;
            active_color_o    <= act_color_r;
            recent_count_o    <= count_r;
            slot_valid_o      <= slot_valid_r;
            slot_index_o      <= slot_index_r;
            slot_color_o      <= slot_color_r;
            state_q           <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  // list length matches the number of occupied cells
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_vld) == int'(len_q))
    else $error("recent length out of step with cell row");

  // occupied cells form a prefix of the row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cell_vld & (cell_vld + RECENT_LIMIT'(1))) == '0)
    else $error("gap in recent cell row");

  // one item in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("item accepted while busy");

  // an active color needs a loaded palette
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && active_valid_o |-> palette_present_o)
    else $error("active color without palette");
`endif

endmodule
